// ----- design/ecev_pkg.sv -----
// ----------------------------------------------------------------------------
// ecev_pkg
// Shared types, constants and helper functions of the easing curve evaluator.
// ----------------------------------------------------------------------------
package ecev_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;
   localparam int ONE_Q     = 1 << FRAC_BITS;

   // field widths
   localparam int PROG_W    = 19;
   localparam int OUT_W     = 20;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;
   localparam int MODE_W    = 2;
   localparam int CX_W      = 17;
   localparam int CY_W      = 20;
   localparam int NSTEP_W   = 13;

   // datapath widths
   localparam int T_W    = FRAC_BITS + 2;        // values in zero..one, signed
   localparam int OPA_W  = T_W;
   localparam int OPB_W  = 21;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int QM_W   = PROD_W - FRAC_BITS + 1;
   localparam int ACC_W  = 26;
   localparam int DIV_NW = ACC_W + FRAC_BITS + 2;
   localparam int DIV_DW = ACC_W + 1;

   // curve modes
   localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEZIER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STEPS  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CURVE_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL_X1       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL_Y1       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL_X2       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL_Y2       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_TOTAL    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_JUMP_AT_START = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WB,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RESP
   } state_type;

   // multiplier operations, in sequence order
   typedef enum logic [3:0] {
      OP_UU,
      OP_SS,
      OP_US,
      OP_A,
      OP_B,
      OP_C,
      OP_M1,
      OP_M2,
      OP_D1,
      OP_D2,
      OP_D3,
      OP_STEP
   } op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // product rounded half away from zero and scaled down
   function automatic logic signed [QM_W-1:0] qround(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] rnd;
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      rnd = (mag + PROD_W'(ONE_Q / 2)) >> FRAC_BITS;
      return p[PROD_W-1] ? QM_W'(-rnd) : QM_W'(rnd);
   endfunction

   // saturate an accumulator to the result field
   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'((1 << (OUT_W - 1)) - 1);
      lo = -ACC_W'(1 << (OUT_W - 1));
      if (v > hi) return OUT_W'(hi);
      if (v < lo) return OUT_W'(lo);
      return OUT_W'(v);
   endfunction

   function automatic op_type next_op(input op_type op);
      unique case (op)
         OP_UU:   return OP_SS;
         OP_SS:   return OP_US;
         OP_US:   return OP_A;
         OP_A:    return OP_B;
         OP_B:    return OP_C;
         OP_C:    return OP_M1;
         OP_M1:   return OP_M2;
         OP_M2:   return OP_D1;
         OP_D1:   return OP_D2;
         OP_D2:   return OP_D3;
         default: return OP_UU;
      endcase
   endfunction

endpackage

// ----- design/ecev_if.sv -----
// ----------------------------------------------------------------------------
// ecev_if
// Request, response and register write channels of the easing evaluator.
// ----------------------------------------------------------------------------
interface ecev_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ecev_pkg::PROG_W-1:0]   progress_in;
   modport source (output valid, output progress_in, input ready);
   modport sink   (input valid, input progress_in, output ready);
endinterface

interface ecev_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ecev_pkg::OUT_W-1:0]    eased_out;
   modport source (output valid, output eased_out, input ready);
   modport sink   (input valid, input eased_out, output ready);
endinterface

interface ecev_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [ecev_pkg::CSR_IDX_W-1:0]       reg_index;
   logic [ecev_pkg::CSR_DAT_W-1:0]       wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- design/easing_curve_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// easing_curve_evaluator_top
// Eased progress for linear, cubic bezier and steps timing curves.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req_bus  in   valid/ready    progress_in  (19b signed Q16)
//  rsp_bus  out  valid/ready    eased_out    (20b signed Q16)
//  csr_bus  in   valid/ready    reg_index (3b), wdata (20b)
//
//  linear mode and bezier end points: result taken straight from the clamped input
//  steps mode: one multiply on the shared multiplier, then a divide
//  bezier: NEWTON_STEPS newton steps, then the y evaluation; each newton step is 11
//  multiplies on the shared multiplier plus a divide (none on a flat derivative)
//  one request at a time; req ready is low from accept until rsp is taken
//  synchronous active-high reset restores the register defaults
// ----------------------------------------------------------------------------
module easing_curve_evaluator_top #(
   parameter int NEWTON_STEPS = 8
) (
   input logic         clock,
   input logic         reset,
   ecev_csr_if.sink    csr_bus,
   ecev_req_if.sink    req_bus,
   ecev_rsp_if.source  rsp_bus
);

   localparam int ITER_W = $clog2(NEWTON_STEPS + 1);
   localparam int T_W    = ecev_pkg::T_W;
   localparam int ACC_W  = ecev_pkg::ACC_W;
   localparam int OPB_W  = ecev_pkg::OPB_W;
   localparam int NW     = ecev_pkg::DIV_NW;
   localparam int DW     = ecev_pkg::DIV_DW;
   localparam int NS_W   = ecev_pkg::NSTEP_W;

   // configuration registers
   logic [ecev_pkg::MODE_W-1:0]       mode_ff;
   logic [ecev_pkg::CX_W-1:0]         x1_ff;
   logic signed [ecev_pkg::CY_W-1:0]  y1_ff;
   logic [ecev_pkg::CX_W-1:0]         x2_ff;
   logic signed [ecev_pkg::CY_W-1:0]  y2_ff;
   logic [NS_W-1:0]                   nstep_ff;
   logic                              jump_ff;

   // sequencer and datapath
   ecev_pkg::state_type               state_ff, state_in;
   ecev_pkg::op_type                  op_ff;
   logic [ITER_W-1:0]                 iter_ff;
   logic                              eval_y_ff;
   logic signed [T_W-1:0]             t_ff, s_ff, uu_ff, ss_ff, us_ff, a_ff, b_ff, c_ff;
   logic signed [ACC_W-1:0]           bx_ff, dx_ff;
   logic [NS_W-1:0]                   k_ff;
   logic signed [ecev_pkg::OUT_W-1:0] res_ff;

   logic                              req_acc;
   logic                              mul_en;
   logic                              div_start;
   logic signed [T_W-1:0]             t_clamp;
   logic signed [T_W-1:0]             u_val;
   logic signed [ecev_pkg::OPA_W-1:0] op_a;
   logic signed [OPB_W-1:0]           op_b;
   logic signed [ecev_pkg::PROD_W-1:0] product;
   logic signed [ecev_pkg::QM_W-1:0]  qm;
   logic signed [ACC_W-1:0]           qm_acc;
   logic signed [ACC_W-1:0]           bx_wb, dx_wb;
   logic [NS_W-1:0]                   n_eff;
   logic [ecev_pkg::PROD_W-1:0]       step_sum;
   logic signed [NW-1:0]              div_num;
   logic signed [DW-1:0]              div_den;
   logic signed [NW-1:0]              quotient;
   ecev_pkg::div_status_type          div_stat;
   logic signed [NW:0]                s_new;
   logic                              is_steps;
   logic                              bez_solve;
   logic                              last_iter;

   assign csr_bus.ready = 1'b1;
   assign req_acc  = req_bus.valid && req_bus.ready;
   assign is_steps = (mode_ff == ecev_pkg::MODE_STEPS);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ecev_pkg::MODE_BEZIER;
         x1_ff    <= 17'd16384;
         y1_ff    <= 20'sd6554;
         x2_ff    <= 17'd16384;
         y2_ff    <= 20'sd65536;
         nstep_ff <= 13'd1;
         jump_ff  <= 1'b0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.reg_index)
            ecev_pkg::REG_CURVE_MODE:    mode_ff  <= csr_bus.wdata[ecev_pkg::MODE_W-1:0];
            ecev_pkg::REG_CTRL_X1:       x1_ff    <= csr_bus.wdata[ecev_pkg::CX_W-1:0];
            ecev_pkg::REG_CTRL_Y1:       y1_ff    <= $signed(csr_bus.wdata);
            ecev_pkg::REG_CTRL_X2:       x2_ff    <= csr_bus.wdata[ecev_pkg::CX_W-1:0];
            ecev_pkg::REG_CTRL_Y2:       y2_ff    <= $signed(csr_bus.wdata);
            ecev_pkg::REG_STEP_TOTAL:    nstep_ff <= csr_bus.wdata[NS_W-1:0];
            ecev_pkg::REG_JUMP_AT_START: jump_ff  <= csr_bus.wdata[0];
            default: ;
         endcase
      end
   end

   // input clamp to zero..one
   always_comb begin
      if (req_bus.progress_in < 0) begin
         t_clamp = '0;
      end else if (req_bus.progress_in > ecev_pkg::PROG_W'(ecev_pkg::ONE_Q)) begin
         t_clamp = T_W'(ecev_pkg::ONE_Q);
      end else begin
         t_clamp = T_W'(req_bus.progress_in);
      end
      bez_solve = (mode_ff == ecev_pkg::MODE_BEZIER) && (t_clamp != '0)
                  && (t_clamp != T_W'(ecev_pkg::ONE_Q));
   end

   // operand select for the shared multiplier
   always_comb begin
      u_val = T_W'(ecev_pkg::ONE_Q) - s_ff;
      n_eff = (nstep_ff == '0) ? NS_W'(1) : nstep_ff;
      op_a  = '0;
      op_b  = '0;
      case (op_ff)
         ecev_pkg::OP_UU: begin op_a = u_val; op_b = OPB_W'(u_val); end
         ecev_pkg::OP_SS: begin op_a = s_ff;  op_b = OPB_W'(s_ff);  end
         ecev_pkg::OP_US: begin op_a = u_val; op_b = OPB_W'(s_ff);  end
         ecev_pkg::OP_A:  begin op_a = uu_ff; op_b = OPB_W'(s_ff);  end
         ecev_pkg::OP_B:  begin op_a = u_val; op_b = OPB_W'(ss_ff); end
         ecev_pkg::OP_C:  begin op_a = ss_ff; op_b = OPB_W'(s_ff);  end
         ecev_pkg::OP_M1: begin
            op_a = a_ff;
            op_b = eval_y_ff ? OPB_W'(y1_ff) : $signed(OPB_W'(x1_ff));
         end
         ecev_pkg::OP_M2: begin
            op_a = b_ff;
            op_b = eval_y_ff ? OPB_W'(y2_ff) : $signed(OPB_W'(x2_ff));
         end
         ecev_pkg::OP_D1: begin op_a = uu_ff; op_b = $signed(OPB_W'(x1_ff)); end
         ecev_pkg::OP_D2: begin
            op_a = us_ff;
            op_b = $signed(OPB_W'(x2_ff)) - $signed(OPB_W'(x1_ff));
         end
         ecev_pkg::OP_D3: begin
            op_a = ss_ff;
            op_b = OPB_W'(ecev_pkg::ONE_Q) - $signed(OPB_W'(x2_ff));
         end
         ecev_pkg::OP_STEP: begin op_a = t_ff; op_b = $signed(OPB_W'(n_eff)); end
         default: ;
      endcase
   end

   ecev_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // rounding and accumulation on writeback
   always_comb begin
      qm       = ecev_pkg::qround(product);
      qm_acc   = ACC_W'(qm);
      bx_wb    = (op_ff == ecev_pkg::OP_M1) ? ACC_W'(c_ff) + (qm_acc <<< 1) + qm_acc
                                            : bx_ff + (qm_acc <<< 1) + qm_acc;
      dx_wb    = (op_ff == ecev_pkg::OP_D1) ? (qm_acc <<< 1) + qm_acc
               : (op_ff == ecev_pkg::OP_D2) ? dx_ff + (qm_acc <<< 2) + (qm_acc <<< 1)
                                            : dx_ff + (qm_acc <<< 1) + qm_acc;
      step_sum = ecev_pkg::PROD_W'(product)
               + (jump_ff ? ecev_pkg::PROD_W'(ecev_pkg::ONE_Q - 1) : '0);
   end

   // divider operands
   always_comb begin
      if (is_steps) begin
         div_num = NW'({k_ff, 17'd0}) + NW'(n_eff);
         div_den = DW'({n_eff, 1'b0});
      end else begin
         div_num = NW'(bx_ff - ACC_W'(t_ff)) <<< ecev_pkg::FRAC_BITS;
         div_den = DW'(dx_ff);
      end
      s_new     = (NW + 1)'(s_ff) - (NW + 1)'(quotient);
      last_iter = (iter_ff + 1'b1) == ITER_W'(NEWTON_STEPS);
   end

   ecev_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (quotient),
      .status   (div_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ecev_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = (bez_solve || is_steps) ? ecev_pkg::ST_ISSUE : ecev_pkg::ST_RESP;
            end
         end
         ecev_pkg::ST_ISSUE: state_in = ecev_pkg::ST_WB;
         ecev_pkg::ST_WB: begin
            case (op_ff)
               ecev_pkg::OP_M2:   state_in = eval_y_ff ? ecev_pkg::ST_RESP : ecev_pkg::ST_ISSUE;
               ecev_pkg::OP_D3:   state_in = (dx_wb == '0) ? ecev_pkg::ST_ISSUE
                                                           : ecev_pkg::ST_DIV_GO;
               ecev_pkg::OP_STEP: state_in = ecev_pkg::ST_DIV_GO;
               default:           state_in = ecev_pkg::ST_ISSUE;
            endcase
         end
         ecev_pkg::ST_DIV_GO: state_in = ecev_pkg::ST_DIV_WAIT;
         ecev_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = is_steps ? ecev_pkg::ST_RESP : ecev_pkg::ST_ISSUE;
            end
         end
         ecev_pkg::ST_RESP: begin
            if (rsp_bus.ready) begin
               state_in = ecev_pkg::ST_IDLE;
            end
         end
         default: state_in = ecev_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_bus.ready     = (state_ff == ecev_pkg::ST_IDLE);
      rsp_bus.valid     = (state_ff == ecev_pkg::ST_RESP);
      rsp_bus.eased_out = res_ff;
      mul_en            = (state_ff == ecev_pkg::ST_ISSUE);
      div_start         = (state_ff == ecev_pkg::ST_DIV_GO);
   end

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ecev_pkg::ST_IDLE;
         op_ff     <= ecev_pkg::OP_UU;
         iter_ff   <= '0;
         eval_y_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ecev_pkg::ST_IDLE: begin
               if (req_acc) begin
                  t_ff      <= t_clamp;
                  s_ff      <= t_clamp;
                  res_ff    <= ecev_pkg::OUT_W'(t_clamp);
                  iter_ff   <= '0;
                  eval_y_ff <= 1'b0;
                  op_ff     <= is_steps ? ecev_pkg::OP_STEP : ecev_pkg::OP_UU;
               end
            end
            ecev_pkg::ST_WB: begin
               op_ff <= ecev_pkg::next_op(op_ff);
               case (op_ff)
                  ecev_pkg::OP_UU:   uu_ff <= T_W'(qm);
                  ecev_pkg::OP_SS:   ss_ff <= T_W'(qm);
                  ecev_pkg::OP_US:   us_ff <= T_W'(qm);
                  ecev_pkg::OP_A:    a_ff  <= T_W'(qm);
                  ecev_pkg::OP_B:    b_ff  <= T_W'(qm);
                  ecev_pkg::OP_C:    c_ff  <= T_W'(qm);
                  ecev_pkg::OP_M1:   bx_ff <= bx_wb;
                  ecev_pkg::OP_M2: begin
                     bx_ff  <= bx_wb;
                     res_ff <= ecev_pkg::sat_out(bx_wb);
                  end
                  ecev_pkg::OP_D1, ecev_pkg::OP_D2: dx_ff <= dx_wb;
                  ecev_pkg::OP_D3: begin
                     dx_ff <= dx_wb;
                     // flat derivative: evaluate y at the current s
                     if (dx_wb == '0) begin
                        eval_y_ff <= 1'b1;
                     end
                  end
                  ecev_pkg::OP_STEP: k_ff <= step_sum[ecev_pkg::FRAC_BITS +: NS_W];
                  default: ;
               endcase
            end
            ecev_pkg::ST_DIV_WAIT: begin
               if (div_stat.done) begin
                  if (is_steps) begin
                     res_ff <= (quotient > NW'(ecev_pkg::ONE_Q))
                               ? ecev_pkg::OUT_W'(ecev_pkg::ONE_Q)
                               : ecev_pkg::OUT_W'(quotient);
                  end else begin
                     // newton update with clamp to zero..one
                     if (s_new < 0) begin
                        s_ff <= '0;
                     end else if (s_new > (NW + 1)'(ecev_pkg::ONE_Q)) begin
                        s_ff <= T_W'(ecev_pkg::ONE_Q);
                     end else begin
                        s_ff <= T_W'(s_new);
                     end
                     iter_ff <= iter_ff + 1'b1;
                     op_ff   <= ecev_pkg::OP_UU;
                     if (last_iter) begin
                        eval_y_ff <= 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != ecev_pkg::ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   a_div_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == ecev_pkg::ST_DIV_WAIT)
      else $error("divider busy outside the divide wait");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ecev_pkg::ST_ISSUE && !eval_y_ff && !is_steps)
      |-> iter_ff < ITER_W'(NEWTON_STEPS))
      else $error("newton iteration count overran");

   a_s_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ecev_pkg::ST_ISSUE && !is_steps
      |-> (s_ff >= 0 && s_ff <= T_W'(ecev_pkg::ONE_Q)))
      else $error("curve parameter left zero..one");
`endif

endmodule

// ----- design/ecev_mul.sv -----
// ----------------------------------------------------------------------------
// ecev_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ecev_mul (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic signed [ecev_pkg::OPA_W-1:0]     op_a,
   input  logic signed [ecev_pkg::OPB_W-1:0]     op_b,
   output logic signed [ecev_pkg::PROD_W-1:0]    product
);

   logic signed [ecev_pkg::PROD_W-1:0] prod_ff;

   // product register
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= ecev_pkg::PROD_W'(op_a) * ecev_pkg::PROD_W'(op_b);
      end
   end

   assign product = prod_ff;

endmodule

// ----- design/ecev_div.sv -----
// ----------------------------------------------------------------------------
// ecev_div
// Radix-2 restoring signed divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module ecev_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [ecev_pkg::DIV_NW-1:0]    dividend,
   input  logic signed [ecev_pkg::DIV_DW-1:0]    divisor,
   output logic signed [ecev_pkg::DIV_NW-1:0]    quotient,
   output ecev_pkg::div_status_type              status
);

   localparam int NW  = ecev_pkg::DIV_NW;
   localparam int DW  = ecev_pkg::DIV_DW;
   localparam int CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    num_ff;
   logic [DW-1:0]    den_ff;
   logic [DW-1:0]    rem_ff;
   logic [NW-1:0]    quo_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DW:0]      rem_sh;
   logic             fits;
   logic [DW:0]      rem_sub;

   // one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, num_ff[NW-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
         den_ff <= divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
         neg_ff <= dividend[NW-1] ^ divisor[DW-1];
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NW-2:0], 1'b0};
         rem_ff <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         quo_ff <= {quo_ff[NW-2:0], fits};
      end
   end

   assign quotient    = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
